// File: rtl/llsp_pkg.sv
// ----------------------------------------------------------------------------
// llsp_pkg
// Shared widths, codes, control word and status types for the server pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package llsp_pkg;

   localparam int LLSP_MAX_SERVERS = 32;
   localparam int LLSP_LOAD_BITS   = 16;

   // fixed field widths of the item and csr channels
   localparam int ACT_W     = 3;
   localparam int SIDX_W    = 5;
   localparam int ADDR_W    = 32;
   localparam int LOADV_W   = 16;
   localparam int MASK_W    = 32;
   localparam int RIDX_W    = 5;
   localparam int STAT_W    = 2;
   localparam int CNT_W     = 6;
   localparam int CSR_IDX_W = 1;
   localparam int STEP_W    = 4;

   typedef enum logic [ACT_W-1:0] {
      ACT_ALLOC      = 3'd0,
      ACT_RELEASE    = 3'd1,
      ACT_SET_ENABLE = 3'd2,
      ACT_SET_LOAD   = 3'd3,
      ACT_SET_ADDR   = 3'd4,
      ACT_FIND       = 3'd5
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_NONE  = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GAME_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTLE_COUNT = 1'b1;

   typedef enum logic {
      RD_PTR = 1'b0,
      RD_IDX = 1'b1
   } rd_sel_type;

   typedef enum logic [1:0] {
      SCAN_NONE = 2'd0,
      SCAN_LOAD = 2'd1,
      SCAN_ADDR = 2'd2
   } scan_type;

   typedef enum logic [2:0] {
      WR_NONE     = 3'd0,
      WR_LOAD_INC = 3'd1,
      WR_LOAD_DEC = 3'd2,
      WR_SET_EN   = 3'd3,
      WR_SET_LOAD = 3'd4,
      WR_SET_ADDR = 3'd5
   } wr_type;

   typedef enum logic [1:0] {
      EM_NONE  = 2'd0,
      EM_BEST  = 2'd1,
      EM_OK    = 2'd2,
      EM_RANGE = 2'd3
   } emit_type;

   typedef enum logic [2:0] {
      J_NEXT      = 3'd0,
      J_SCAN      = 3'd1,
      J_SCAN_FREE = 3'd2,
      J_BAD_W     = 3'd3,
      J_BAD_A     = 3'd4
   } jcond_type;

   typedef struct packed {
      rd_sel_type        rd_sel;
      scan_type          scan;
      wr_type            wr;
      emit_type          emit;
      jcond_type         jcond;
      logic [STEP_W-1:0] target;
      logic              last;
   } ucw_type;

   typedef struct packed {
      ucw_type cw;
      logic    go;
      logic    start;
   } seq_ctl_type;

   typedef struct packed {
      logic scan_more;
      logic have;
      logic bad_w;
      logic bad_a;
      logic out_busy;
   } dp_flags_type;

endpackage

// File: rtl/llsp_seq.sv
// ----------------------------------------------------------------------------
// llsp_seq
// Microprogram sequencer: control store, step counter and jump logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llsp_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [llsp_pkg::ACT_W-1:0]  req_action,
   input  llsp_pkg::dp_flags_type      flags,
   output llsp_pkg::seq_ctl_type       ctl
);
   import llsp_pkg::*;

   localparam logic [STEP_W-1:0] S_IDLE       = 4'd0;
   localparam logic [STEP_W-1:0] S_ALLOC_SCAN = 4'd1;
   localparam logic [STEP_W-1:0] S_ALLOC_DONE = 4'd2;
   localparam logic [STEP_W-1:0] S_REL_CHK    = 4'd3;
   localparam logic [STEP_W-1:0] S_REL_WR     = 4'd4;
   localparam logic [STEP_W-1:0] S_LD_CHK     = 4'd5;
   localparam logic [STEP_W-1:0] S_LD_WR      = 4'd6;
   localparam logic [STEP_W-1:0] S_EN_CHK     = 4'd7;
   localparam logic [STEP_W-1:0] S_EN_WR      = 4'd8;
   localparam logic [STEP_W-1:0] S_ADDR_CHK   = 4'd9;
   localparam logic [STEP_W-1:0] S_ADDR_WR    = 4'd10;
   localparam logic [STEP_W-1:0] S_RANGE      = 4'd11;
   localparam logic [STEP_W-1:0] S_FIND_SCAN  = 4'd12;
   localparam logic [STEP_W-1:0] S_FIND_DONE  = 4'd13;
   localparam logic [STEP_W-1:0] S_NOP        = 4'd14;

   function automatic ucw_type ucode(input logic [STEP_W-1:0] s);
      ucw_type w;
      w = '{rd_sel: RD_PTR, scan: SCAN_NONE, wr: WR_NONE, emit: EM_NONE,
            jcond: J_NEXT, target: S_IDLE, last: 1'b0};
      case (s)
         S_IDLE: begin
         end
         S_ALLOC_SCAN: begin
            w.scan   = SCAN_LOAD;
            w.jcond  = J_SCAN;
            w.target = S_ALLOC_SCAN;
         end
         S_ALLOC_DONE: begin
            w.wr   = WR_LOAD_INC;
            w.emit = EM_BEST;
            w.last = 1'b1;
         end
         S_REL_CHK, S_LD_CHK: begin
            w.rd_sel = RD_IDX;
            w.jcond  = J_BAD_W;
            w.target = S_RANGE;
         end
         S_REL_WR: begin
            w.rd_sel = RD_IDX;
            w.wr     = WR_LOAD_DEC;
            w.emit   = EM_OK;
            w.last   = 1'b1;
         end
         S_LD_WR: begin
            w.rd_sel = RD_IDX;
            w.wr     = WR_SET_LOAD;
            w.emit   = EM_OK;
            w.last   = 1'b1;
         end
         S_EN_CHK: begin
            w.jcond  = J_BAD_W;
            w.target = S_RANGE;
         end
         S_EN_WR: begin
            w.wr   = WR_SET_EN;
            w.emit = EM_OK;
            w.last = 1'b1;
         end
         S_ADDR_CHK: begin
            w.jcond  = J_BAD_A;
            w.target = S_RANGE;
         end
         S_ADDR_WR: begin
            w.wr   = WR_SET_ADDR;
            w.emit = EM_OK;
            w.last = 1'b1;
         end
         S_RANGE: begin
            w.emit = EM_RANGE;
            w.last = 1'b1;
         end
         S_FIND_SCAN: begin
            w.scan   = SCAN_ADDR;
            w.jcond  = J_SCAN_FREE;
            w.target = S_FIND_SCAN;
         end
         S_FIND_DONE: begin
            w.emit = EM_BEST;
            w.last = 1'b1;
         end
         S_NOP: begin
            w.emit = EM_OK;
            w.last = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

   function automatic logic [STEP_W-1:0] dispatch(input logic [ACT_W-1:0] a);
      logic [STEP_W-1:0] s;
      case (a)
         ACT_ALLOC:      s = S_ALLOC_SCAN;
         ACT_RELEASE:    s = S_REL_CHK;
         ACT_SET_ENABLE: s = S_EN_CHK;
         ACT_SET_LOAD:   s = S_LD_CHK;
         ACT_SET_ADDR:   s = S_ADDR_CHK;
         ACT_FIND:       s = S_FIND_SCAN;
         default:        s = S_NOP;
      endcase
      return s;
   endfunction

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucw_type           cw;
   logic              idle;
   logic              go;
   logic              taken;

   assign cw   = ucode(step_ff);
   assign idle = (step_ff == S_IDLE);
   // an emitting step waits while the previous result is still held
   assign go   = !((cw.emit != EM_NONE) && flags.out_busy);

   always_comb begin
      case (cw.jcond)
         J_NEXT:      taken = 1'b0;
         J_SCAN:      taken = flags.scan_more;
         J_SCAN_FREE: taken = flags.scan_more && !flags.have;
         J_BAD_W:     taken = flags.bad_w;
         J_BAD_A:     taken = flags.bad_a;
         default:     taken = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (idle) begin
         if (req_valid) begin
            step_in = dispatch(req_action);
         end
      end else if (go) begin
         if (cw.last) begin
            step_in = S_IDLE;
         end else if (taken) begin
            step_in = cw.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign req_stall = !idle;
   assign ctl.cw    = cw;
   assign ctl.go    = go && !idle;
   assign ctl.start = idle && req_valid;

endmodule

// File: rtl/llsp_dp.sv
// ----------------------------------------------------------------------------
// llsp_dp
// Datapath: request latch, pool and address memories, scan unit, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llsp_dp #(
   parameter int MAX_SERVERS = llsp_pkg::LLSP_MAX_SERVERS,
   parameter int LOAD_BITS   = llsp_pkg::LLSP_LOAD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  llsp_pkg::seq_ctl_type         ctl,
   output llsp_pkg::dp_flags_type        flags,
   input  logic [llsp_pkg::SIDX_W-1:0]   req_server_index,
   input  logic                          req_server_kind,
   input  logic [llsp_pkg::ADDR_W-1:0]   req_ip_address,
   input  logic                          req_enable_flag,
   input  logic [llsp_pkg::LOADV_W-1:0]  req_load_value,
   input  logic [llsp_pkg::MASK_W-1:0]   req_map_open_mask,
   input  logic [llsp_pkg::CNT_W-1:0]    game_count,
   input  logic [llsp_pkg::CNT_W-1:0]    battle_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [llsp_pkg::RIDX_W-1:0]   rsp_result_index,
   output logic [llsp_pkg::STAT_W-1:0]   rsp_status
);
   import llsp_pkg::*;

   localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int PTR_W  = $clog2(MAX_SERVERS + 1);
   localparam int DEPTH  = 2 ** IDX_W;
   localparam int ADEPTH = 2 * DEPTH;
   localparam int ENT_W  = LOAD_BITS + 1;
   localparam int CMP_W  = (LOAD_BITS > LOADV_W) ? LOAD_BITS : LOADV_W;
   localparam int CNTX_W = CNT_W + 1;
   localparam logic [CNTX_W-1:0]    MAX_X    = CNTX_W'(MAX_SERVERS);
   localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

   // request latch
   logic [SIDX_W-1:0]  idx_ff;
   logic               kind_ff;
   logic [ADDR_W-1:0]  ip_ff;
   logic               en_ff;
   logic [LOADV_W-1:0] loadv_ff;
   logic [MASK_W-1:0]  mask_ff;

   // memories: worker entry is {enable, load}
   logic [ENT_W-1:0]   w_mem_ff [DEPTH];
   logic [DEPTH-1:0]   w_val_ff;
   logic [ENT_W-1:0]   w_rd_ff;
   logic               w_rv_ff;
   logic [ADDR_W-1:0]  a_mem_ff [ADEPTH];
   logic [ADEPTH-1:0]  a_val_ff;
   logic [ADDR_W-1:0]  a_rd_ff;
   logic               a_rv_ff;

   // scan unit
   logic [PTR_W-1:0]     ptr_ff;
   logic                 look_ff;
   logic [IDX_W-1:0]     look_idx_ff;
   logic                 have_ff;
   logic [IDX_W-1:0]     best_ff;
   logic [LOAD_BITS-1:0] best_load_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [RIDX_W-1:0]    rsp_idx_ff;
   logic [STAT_W-1:0]    rsp_status_ff;

   logic [CNTX_W-1:0]    wn;
   logic [CNTX_W-1:0]    gn;
   logic [CNTX_W-1:0]    scan_n;
   logic                 scan_more;
   logic [IDX_W-1:0]     ridx;
   logic [IDX_W-1:0]     sidx;
   logic [ENT_W-1:0]     w_data;
   logic                 rd_en;
   logic [LOAD_BITS-1:0] rd_load;
   logic [ADDR_W-1:0]    a_data;
   logic [DEPTH-1:0]     mask_ext;
   logic                 hit;
   logic                 w_we;
   logic [IDX_W-1:0]     w_waddr;
   logic [ENT_W-1:0]     w_wdata;
   logic                 a_we;
   logic [LOAD_BITS-1:0] inc_load;
   logic [LOAD_BITS-1:0] dec_load;
   logic [CMP_W-1:0]     ldx;
   logic [LOAD_BITS-1:0] clamp_load;
   logic                 emit_go;

   // counts above the pool size act as the pool size
   assign wn = ({1'b0, battle_count} > MAX_X) ? MAX_X : {1'b0, battle_count};
   assign gn = ({1'b0, game_count} > MAX_X) ? MAX_X : {1'b0, game_count};

   assign scan_n    = ((ctl.cw.scan == SCAN_LOAD) || kind_ff) ? wn : gn;
   assign scan_more = CNTX_W'(ptr_ff) < scan_n;

   assign sidx = IDX_W'(idx_ff);
   assign ridx = (ctl.cw.rd_sel == RD_IDX) ? sidx : ptr_ff[IDX_W-1:0];

   assign w_data  = w_rv_ff ? w_rd_ff : '0;
   assign rd_en   = w_data[LOAD_BITS];
   assign rd_load = w_data[LOAD_BITS-1:0];
   assign a_data  = a_rv_ff ? a_rd_ff : '0;

   // workers beyond the mask width are never eligible
   for (genvar g = 0; g < DEPTH; g++) begin : g_mask
      if (g < MASK_W && g < MAX_SERVERS) begin : g_in
         assign mask_ext[g] = mask_ff[g];
      end else begin : g_out
         assign mask_ext[g] = 1'b0;
      end
   end

   always_comb begin
      case (ctl.cw.scan)
         SCAN_LOAD: hit = look_ff && rd_en && mask_ext[look_idx_ff]
                          && (!have_ff || (rd_load < best_load_ff));
         SCAN_ADDR: hit = look_ff && !have_ff && (a_data == ip_ff);
         default:   hit = 1'b0;
      endcase
   end

   assign inc_load   = (best_load_ff == LOAD_MAX) ? best_load_ff : best_load_ff + 1'b1;
   assign dec_load   = (rd_load == '0) ? rd_load : rd_load - 1'b1;
   assign ldx        = CMP_W'(loadv_ff);
   assign clamp_load = (ldx > CMP_W'(LOAD_MAX)) ? LOAD_MAX : LOAD_BITS'(ldx);

   always_comb begin
      w_we    = 1'b0;
      w_waddr = sidx;
      w_wdata = {rd_en, rd_load};
      a_we    = 1'b0;
      case (ctl.cw.wr)
         WR_LOAD_INC: begin
            w_we    = have_ff;
            w_waddr = best_ff;
            w_wdata = {1'b1, inc_load};
         end
         WR_LOAD_DEC: begin
            w_we    = 1'b1;
            w_wdata = {rd_en, dec_load};
         end
         WR_SET_EN: begin
            w_we    = 1'b1;
            w_wdata = {en_ff, {LOAD_BITS{1'b0}}};
         end
         WR_SET_LOAD: begin
            w_we    = 1'b1;
            w_wdata = {rd_en, clamp_load};
         end
         WR_SET_ADDR: begin
            a_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         idx_ff   <= req_server_index;
         kind_ff  <= req_server_kind;
         ip_ff    <= req_ip_address;
         en_ff    <= req_enable_flag;
         loadv_ff <= req_load_value;
         mask_ff  <= req_map_open_mask;
      end
   end

   always_ff @(posedge clock) begin
      w_rd_ff <= w_mem_ff[ridx];
      a_rd_ff <= a_mem_ff[{kind_ff, ridx}];
      if (ctl.go && w_we) begin
         w_mem_ff[w_waddr] <= w_wdata;
      end
      if (ctl.go && a_we) begin
         a_mem_ff[{kind_ff, sidx}] <= ip_ff;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         w_val_ff <= '0;
         a_val_ff <= '0;
         w_rv_ff  <= 1'b0;
         a_rv_ff  <= 1'b0;
      end else begin
         w_rv_ff <= w_val_ff[ridx];
         a_rv_ff <= a_val_ff[{kind_ff, ridx}];
         if (ctl.go && w_we) begin
            w_val_ff[w_waddr] <= 1'b1;
         end
         if (ctl.go && a_we) begin
            a_val_ff[{kind_ff, sidx}] <= 1'b1;
         end
      end
   end

   // scan control: one read issued per cycle, compared in the following cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         look_ff <= 1'b0;
         have_ff <= 1'b0;
      end else if (ctl.start) begin
         ptr_ff  <= '0;
         look_ff <= 1'b0;
         have_ff <= 1'b0;
      end else if (ctl.go && (ctl.cw.scan != SCAN_NONE)) begin
         if (hit) begin
            have_ff <= 1'b1;
         end
         if (scan_more) begin
            ptr_ff  <= ptr_ff + 1'b1;
            look_ff <= 1'b1;
         end else begin
            look_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         best_ff      <= '0;
         best_load_ff <= '0;
      end else if (ctl.go && hit) begin
         best_ff      <= look_idx_ff;
         best_load_ff <= rd_load;
      end
      if (ctl.go && scan_more) begin
         look_idx_ff <= ptr_ff[IDX_W-1:0];
      end
   end

   // result register
   assign emit_go = ctl.go && (ctl.cw.emit != EM_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         case (ctl.cw.emit)
            EM_BEST: begin
               rsp_found_ff  <= have_ff;
               rsp_idx_ff    <= have_ff ? RIDX_W'(best_ff) : '0;
               rsp_status_ff <= have_ff ? ST_OK : ST_NONE;
            end
            EM_RANGE: begin
               rsp_found_ff  <= 1'b0;
               rsp_idx_ff    <= '0;
               rsp_status_ff <= ST_RANGE;
            end
            default: begin
               rsp_found_ff  <= 1'b0;
               rsp_idx_ff    <= '0;
               rsp_status_ff <= ST_OK;
            end
         endcase
      end
   end

   assign flags.scan_more = scan_more;
   assign flags.have      = have_ff;
   assign flags.bad_w     = !(CNTX_W'(idx_ff) < wn);
   assign flags.bad_a     = !(CNTX_W'(idx_ff) < (kind_ff ? wn : gn));
   assign flags.out_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// File: rtl/least_loaded_server_pool.sv
// ----------------------------------------------------------------------------
// least_loaded_server_pool
// Least-loaded worker allocator with address lookup for two server tables.
// Requests are run one at a time by a small microprogram. Allocate and find
// scan the table one entry per clock through a registered memory read, and
// the result is loaded once the scan has passed the last counted entry; a
// find that matches stops scanning once the match has been registered.
// Release, set enable, set load and set address check the index against the
// table count, then write and load an ok result, or load a range result;
// unused action codes load an ok result directly. req_stall is high from
// acceptance until the result has been loaded into the output register; a
// held result only delays the step that writes the next one. Both tables
// read as zero after reset through per-entry valid bits, so no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module least_loaded_server_pool #(
   parameter int MAX_SERVERS = llsp_pkg::LLSP_MAX_SERVERS,
   parameter int LOAD_BITS   = llsp_pkg::LLSP_LOAD_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [llsp_pkg::ACT_W-1:0]      req_action,
   input  logic [llsp_pkg::SIDX_W-1:0]     req_server_index,
   input  logic                            req_server_kind,
   input  logic [llsp_pkg::ADDR_W-1:0]     req_ip_address,
   input  logic                            req_enable_flag,
   input  logic [llsp_pkg::LOADV_W-1:0]    req_load_value,
   input  logic [llsp_pkg::MASK_W-1:0]     req_map_open_mask,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [llsp_pkg::RIDX_W-1:0]     rsp_result_index,
   output logic [llsp_pkg::STAT_W-1:0]     rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [llsp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [llsp_pkg::CNT_W-1:0]      csr_wdata
);
   import llsp_pkg::*;

   logic [CNT_W-1:0] game_cnt_ff;
   logic [CNT_W-1:0] battle_cnt_ff;
   seq_ctl_type      ctl;
   dp_flags_type     flags;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         game_cnt_ff   <= '0;
         battle_cnt_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAME_COUNT:   game_cnt_ff   <= csr_wdata;
            CSR_BATTLE_COUNT: battle_cnt_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   llsp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .flags      (flags),
      .ctl        (ctl)
   );

   llsp_dp #(
      .MAX_SERVERS (MAX_SERVERS),
      .LOAD_BITS   (LOAD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .flags             (flags),
      .req_server_index  (req_server_index),
      .req_server_kind   (req_server_kind),
      .req_ip_address    (req_ip_address),
      .req_enable_flag   (req_enable_flag),
      .req_load_value    (req_load_value),
      .req_map_open_mask (req_map_open_mask),
      .game_count        (game_cnt_ff),
      .battle_count      (battle_cnt_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_result_index  (rsp_result_index),
      .rsp_status        (rsp_status)
   );

   a_found_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
      else $error("found result without ok status");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_result_index == '0))
      else $error("result index nonzero when nothing found");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not stalled after accepting an item");

endmodule
